// ----- rtl/core/contiguous_frame_allocator_top_assert.svh -----
// Assertion helpers for the frame allocator checker.
`ifndef CONTIGUOUS_FRAME_ALLOCATOR_TOP_ASSERT_SVH
`define CONTIGUOUS_FRAME_ALLOCATOR_TOP_ASSERT_SVH
`define CFA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/core/cfa_pkg.sv -----
package cfa_pkg;
  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_COMPACT = 2'd1,
    ST_SKIP    = 2'd2,
    ST_FREED   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FIT_NEXT  = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_t;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_FREE, S_SCAN, S_CHECK, S_COMPACT, S_FILL, S_DONE
  } state_t;
endpackage

// ----- rtl/core/cfa_cell.sv -----
// One frame entry of the owner chain.
module cfa_cell (
  input  logic       clk,
  input  logic       rst,
  input  logic       shift,
  input  logic       squeeze,
  input  logic       phase,
  input  logic       odd,
  input  logic [7:0] left_val,
  input  logic [7:0] right_val,
  output logic [7:0] val
);
  logic [7:0] val_next;
  logic       pair_left;

  // In a squeeze step the cell pairs with its right neighbor when its index
  // parity matches the phase, and with its left neighbor otherwise.
  assign pair_left = (odd == phase);

  always_comb begin
    val_next = val;
    if (shift) begin
      val_next = right_val;
    end else if (squeeze) begin
      // A free entry trades places with a used entry on its right.
      if (pair_left) begin
        if (val == '0 && right_val != '0) val_next = right_val;
      end else begin
        if (left_val == '0 && val != '0) val_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      val <= '0;
    end else begin
      val <= val_next;
    end
  end
endmodule

// ----- rtl/core/contiguous_frame_allocator_top.sv -----
// Frame allocator on a chain of N = NUM_FRAMES cells, one owner entry per cell.
// A free walks every frame in S_FREE, then S_DONE. An allocate scans in S_SCAN and decides in
// S_CHECK: place directly via S_FILL, compact in S_COMPACT then S_FILL, or skip to S_DONE.
// A rejected request goes straight to S_DONE. One request is in flight; each pass walks
// every frame once, and compaction needs N squeeze steps.
// Reset (rst, synchronous, high) frees every frame, clears the pointers, fit_mode = 0.
module contiguous_frame_allocator_top import cfa_pkg::*; #(
  parameter int NUM_FRAMES = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       cmd,
  input  logic [7:0] owner,
  input  logic [8:0] size,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [7:0] base,
  output logic [8:0] moved_frames,
  output logic [8:0] freed_frames
);
  localparam int CW = $clog2(NUM_FRAMES + 1);

  logic [1:0] fit_mode;
  state_t state, state_next;

  logic [7:0] ring [NUM_FRAMES];
  logic [7:0] head;
  logic [7:0] tail_in;
  logic       shift;
  logic       squeeze;
  logic       phase;

  logic [7:0]    r_owner;
  logic [CW-1:0] r_size;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_step;
  logic          last;
  logic [CW-1:0] used;
  logic [CW-1:0] nptr;
  logic [CW-1:0] run_len;
  logic [CW-1:0] run_len_inc;
  logic          seen_free;
  logic [CW-1:0] moved_cnt;
  logic          lo_found, hi_found, run_found;
  logic [CW-1:0] lo_at, hi_at, best_at, best_len;
  logic [CW-1:0] at;
  logic [CW-1:0] moved;
  logic [CW-1:0] freed;
  status_t       res_status;

  logic          reject;
  logic          clear_hit;
  logic          in_block;
  logic          fits_now;
  logic          run_end;
  logic          run_better;
  logic [CW-1:0] cand_at;
  logic [CW-1:0] run_start;
  logic          hit;
  logic [CW-1:0] hit_at;
  logic          room;

  genvar g;
  generate
    for (g = 0; g < NUM_FRAMES; g++) begin : g_cell
      logic [7:0] left_val;
      logic [7:0] right_val;
      if (g == 0) begin : g_first
        // Cell 0 has no left partner; a nonzero value keeps it from being cleared.
        assign left_val = 8'd1;
      end else begin : g_inner_l
        assign left_val = ring[g - 1];
      end
      if (g == NUM_FRAMES - 1) begin : g_last
        assign right_val = tail_in;
      end else begin : g_inner_r
        assign right_val = ring[g + 1];
      end
      cfa_cell u_cell (
        .clk(clk), .rst(rst), .shift(shift), .squeeze(squeeze), .phase(phase),
        .odd(1'(g % 2)), .left_val(left_val), .right_val(right_val), .val(ring[g])
      );
    end
  endgenerate

  // Every pass starts aligned, so cell 0 holds frame cnt during a pass.
  assign head        = ring[0];
  assign last        = (cnt == CW'(NUM_FRAMES - 1));
  assign cnt_step    = last ? '0 : cnt + CW'(1);
  assign run_len_inc = run_len + CW'(1);
  assign reject      = (owner == '0) || (size == '0) || (int'(size) > NUM_FRAMES);
  assign clear_hit   = (r_owner != '0) && (head == r_owner);
  assign in_block    = (cnt >= at) && (cnt < at + r_size);
  assign fits_now    = run_len_inc >= r_size;
  assign cand_at     = cnt + CW'(1) - r_size;
  assign run_start   = cnt + CW'(1) - run_len_inc;
  // A maximal free run ends here when the next frame is used or memory ends.
  assign run_end     = last || (ring[1] != '0);
  assign run_better  = !run_found || (fit_mode == FIT_BEST ? run_len_inc < best_len
                                                           : run_len_inc > best_len);
  assign hit         = (fit_mode == FIT_NEXT) ? (hi_found || lo_found) : run_found;
  assign hit_at      = (fit_mode == FIT_NEXT) ? (hi_found ? hi_at : lo_at) : best_at;
  assign room        = (CW'(NUM_FRAMES) - used) >= r_size;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (cmd == CMD_FREE) state_next = S_FREE;
          else if (reject) state_next = S_DONE;
          else state_next = S_SCAN;
        end
      end
      S_FREE:    if (last) state_next = S_DONE;
      S_SCAN:    if (last) state_next = S_CHECK;
      S_CHECK: begin
        if (hit) state_next = S_FILL;
        else if (room) state_next = S_COMPACT;
        else state_next = S_DONE;
      end
      S_COMPACT: if (last) state_next = S_FILL;
      S_FILL:    if (last) state_next = S_DONE;
      S_DONE:    if (out_ready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    shift     = 1'b0;
    squeeze   = 1'b0;
    tail_in   = '0;
    in_ready  = 1'b0;
    cfg_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cfg_ready = !in_valid;
      end
      S_FREE: begin
        shift   = 1'b1;
        tail_in = clear_hit ? '0 : head;
      end
      S_SCAN: begin
        shift   = 1'b1;
        tail_in = head;
      end
      S_COMPACT: squeeze = 1'b1;
      S_FILL: begin
        shift   = 1'b1;
        tail_in = in_block ? r_owner : head;
      end
      S_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fit_mode   <= '0;
      used       <= '0;
      nptr       <= '0;
      r_owner    <= '0;
      r_size     <= '0;
      cnt        <= '0;
      phase      <= 1'b0;
      run_len    <= '0;
      seen_free  <= 1'b0;
      moved_cnt  <= '0;
      lo_found   <= 1'b0;
      lo_at      <= '0;
      hi_found   <= 1'b0;
      hi_at      <= '0;
      run_found  <= 1'b0;
      best_len   <= '0;
      best_at    <= '0;
      at         <= '0;
      moved      <= '0;
      freed      <= '0;
      res_status <= ST_SKIP;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) fit_mode <= cfg_data;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            r_owner    <= owner;
            r_size     <= CW'(size);
            cnt        <= '0;
            run_len    <= '0;
            seen_free  <= 1'b0;
            moved_cnt  <= '0;
            lo_found   <= 1'b0;
            hi_found   <= 1'b0;
            run_found  <= 1'b0;
            best_len   <= '0;
            at         <= '0;
            moved      <= '0;
            freed      <= '0;
            res_status <= (cmd == CMD_FREE) ? ST_FREED : ST_SKIP;
          end
        end
        S_FREE: begin
          cnt <= cnt_step;
          if (clear_hit) begin
            freed <= freed + CW'(1);
            used  <= used - CW'(1);
          end
        end
        S_SCAN: begin
          cnt <= cnt_step;
          if (head == '0) begin
            run_len   <= run_len_inc;
            seen_free <= 1'b1;
            if (fits_now && !lo_found) begin
              lo_found <= 1'b1;
              lo_at    <= cand_at;
            end
            if (fits_now && !hi_found && cand_at >= nptr) begin
              hi_found <= 1'b1;
              hi_at    <= cand_at;
            end
            if (run_end && fits_now && run_better) begin
              run_found <= 1'b1;
              best_len  <= run_len_inc;
              best_at   <= run_start;
            end
          end else begin
            run_len <= '0;
            // Used frames behind a free one change place if compaction runs.
            if (seen_free) moved_cnt <= moved_cnt + CW'(1);
          end
        end
        S_CHECK: begin
          phase <= 1'b0;
          if (hit) begin
            at         <= hit_at;
            res_status <= ST_PLACED;
          end else if (room) begin
            // After compaction the only free run starts right after the used frames.
            at         <= used;
            moved      <= moved_cnt;
            nptr       <= '0;
            res_status <= ST_COMPACT;
          end else begin
            res_status <= ST_SKIP;
          end
        end
        S_COMPACT: begin
          cnt   <= cnt_step;
          phase <= ~phase;
        end
        S_FILL: begin
          cnt <= cnt_step;
          if (last) begin
            used <= used + r_size;
            nptr <= at + r_size;
          end
        end
        default: ;
      endcase
    end
  end

  assign status       = res_status;
  assign base         = 8'(at);
  assign moved_frames = 9'(moved);
  assign freed_frames = 9'(freed);
endmodule

// ----- rtl/core/cfa_checker.sv -----
module cfa_checker import cfa_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic [7:0] base,
  input logic [8:0] freed_frames
);
`include "contiguous_frame_allocator_top_assert.svh"
  `CFA_ASSERT_IMPL(a_one_side, out_valid, !in_ready)
  `CFA_ASSERT_IMPL(a_skip_base, out_valid && status == ST_SKIP, base == 8'd0)
  `CFA_ASSERT_IMPL(a_free_base, out_valid && status == ST_FREED, base == 8'd0)
  `CFA_ASSERT_IMPL(a_freed_only, out_valid && status != ST_FREED, freed_frames == 9'd0)
  `CFA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status))
endmodule

bind contiguous_frame_allocator_top cfa_checker u_cfa_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .status(status),
  .base(base), .freed_frames(freed_frames)
);
